// File: sv/rmq_pkg.sv
package rmq_pkg;

    localparam int NUM_COMP = 4;

    // lane order of the four components
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_W = 3;

    // sideband that travels with every transaction down the pipeline
    typedef struct packed {
        logic                valid;
        logic                invalid;
        logic [NUM_COMP-1:0] neg;
    } rmq_tag_t;

    typedef enum logic [1:0] {
        BR_X = 2'd0,
        BR_Y = 2'd1,
        BR_Z = 2'd2,
        BR_W = 2'd3
    } rmq_branch_t;

endpackage

// File: sv/rmq_front.sv
module rmq_front #(
    parameter int FRAC_BITS = 14,
    parameter int TW        = 19,
    parameter int MW        = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [15:0]            m00,
    input  logic signed [15:0]            m01,
    input  logic signed [15:0]            m02,
    input  logic signed [15:0]            m10,
    input  logic signed [15:0]            m11,
    input  logic signed [15:0]            m12,
    input  logic signed [15:0]            m20,
    input  logic signed [15:0]            m21,
    input  logic signed [15:0]            m22,
    output rmq_pkg::rmq_tag_t             tag,
    output logic [rmq_pkg::NUM_COMP-1:0][MW-1:0] mag,
    output logic [MW-1:0]                 t_mag
);
    import rmq_pkg::*;

    localparam logic signed [TW-1:0] ONE_T =
        {{(TW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic signed [TW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [TW-1:0] t_next;
    logic signed [NUM_COMP-1:0][TW-1:0] c_next;
    logic signed [TW-1:0] diag_sum;
    rmq_branch_t          br;

    logic                       vld1_reg;
    logic signed [TW-1:0]       t_reg;
    logic [NUM_COMP-1:0][TW-1:0] c_reg;

    rmq_tag_t                    tag_reg, tag_next;
    logic [NUM_COMP-1:0][MW-1:0] mag_reg, mag_next;
    logic [MW-1:0]               tmag_reg, tmag_next;

    assign a00 = {{(TW-16){m00[15]}}, m00};
    assign a01 = {{(TW-16){m01[15]}}, m01};
    assign a02 = {{(TW-16){m02[15]}}, m02};
    assign a10 = {{(TW-16){m10[15]}}, m10};
    assign a11 = {{(TW-16){m11[15]}}, m11};
    assign a12 = {{(TW-16){m12[15]}}, m12};
    assign a20 = {{(TW-16){m20[15]}}, m20};
    assign a21 = {{(TW-16){m21[15]}}, m21};
    assign a22 = {{(TW-16){m22[15]}}, m22};

    assign diag_sum = a00 + a11;

    // branch choice
    always_comb
    begin
        priority if (a22 < 0 && a00 > a11)
            br = BR_X;
        else if (a22 < 0)
            br = BR_Y;
        else if (diag_sum < 0)
            br = BR_Z;
        else
            br = BR_W;
    end

    always_comb
    begin
        unique case (br)
            BR_X:
            begin
                t_next = ONE_T + a00 - a11 - a22;
                c_next[LANE_X] = t_next;
                c_next[LANE_Y] = a10 + a01;
                c_next[LANE_Z] = a02 + a20;
                c_next[LANE_W] = a21 - a12;
            end
            BR_Y:
            begin
                t_next = ONE_T - a00 + a11 - a22;
                c_next[LANE_X] = a10 + a01;
                c_next[LANE_Y] = t_next;
                c_next[LANE_Z] = a21 + a12;
                c_next[LANE_W] = a02 - a20;
            end
            BR_Z:
            begin
                t_next = ONE_T - a00 - a11 + a22;
                c_next[LANE_X] = a02 + a20;
                c_next[LANE_Y] = a21 + a12;
                c_next[LANE_Z] = t_next;
                c_next[LANE_W] = a10 - a01;
            end
            default:
            begin
                t_next = ONE_T + a00 + a11 + a22;
                c_next[LANE_X] = a21 - a12;
                c_next[LANE_Y] = a02 - a20;
                c_next[LANE_Z] = a10 - a01;
                c_next[LANE_W] = t_next;
            end
        endcase
    end

    // sign and magnitude split
    always_comb
    begin
        tag_next.valid   = vld1_reg;
        tag_next.invalid = (t_reg <= 0);
        for (int i = 0; i < NUM_COMP; i++)
        begin
            tag_next.neg[i] = c_reg[i][TW-1];
            mag_next[i] = c_reg[i][TW-1] ? MW'(-c_reg[i]) : c_reg[i][MW-1:0];
        end
        tmag_next = tag_next.invalid ? '0 : t_reg[MW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            tag_reg  <= '0;
        end
        else
        begin
            vld1_reg <= start;
            tag_reg  <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        c_reg    <= c_next;
        mag_reg  <= mag_next;
        tmag_reg <= tmag_next;
    end

    assign tag   = tag_reg;
    assign mag   = mag_reg;
    assign t_mag = tmag_reg;

endmodule

// File: sv/rmq_sqrt.sv
module rmq_sqrt #(
    parameter int FRAC_BITS = 14,
    parameter int MW        = 18,
    parameter int RW        = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rmq_pkg::rmq_tag_t                    tag_in,
    input  logic [rmq_pkg::NUM_COMP-1:0][MW-1:0] mag_in,
    input  logic [MW-1:0]                        t_in,
    output rmq_pkg::rmq_tag_t                    tag_out,
    output logic [rmq_pkg::NUM_COMP-1:0][MW-1:0] mag_out,
    output logic [RW-1:0]                        root
);
    import rmq_pkg::*;

    localparam int SW = 2 * RW;

    logic [SW-1:0]               v_reg    [RW];
    logic [RW+1:0]               rem_reg  [RW];
    logic [RW-1:0]               root_reg [RW];
    rmq_tag_t                    tag_reg  [RW];
    logic [NUM_COMP-1:0][MW-1:0] mag_reg  [RW];

    // one root bit per stage
    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [SW-1:0]               v_p;
        logic [RW+1:0]               rem_p;
        logic [RW-1:0]               root_p;
        rmq_tag_t                    tag_p;
        logic [NUM_COMP-1:0][MW-1:0] mag_p;
        logic [RW+1:0]               rem_sh, trial, rem_next;
        logic [RW-1:0]               root_next;

        if (k == 0)
        begin : g_first
            assign v_p    = SW'({t_in, {FRAC_BITS{1'b0}}});
            assign rem_p  = '0;
            assign root_p = '0;
            assign tag_p  = tag_in;
            assign mag_p  = mag_in;
        end
        else
        begin : g_next
            assign v_p    = v_reg[k-1];
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign tag_p  = tag_reg[k-1];
            assign mag_p  = mag_reg[k-1];
        end

        assign rem_sh = {rem_p[RW-1:0], v_p[SW-1-2*k -: 2]};
        assign trial  = {root_p, 2'b01};

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_p[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_p[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[k] <= '0;
            else
                tag_reg[k] <= tag_p;
        end

        always_ff @(posedge clk)
        begin
            v_reg[k]    <= v_p;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            mag_reg[k]  <= mag_p;
        end
    end

    assign tag_out = tag_reg[RW-1];
    assign mag_out = mag_reg[RW-1];
    assign root    = root_reg[RW-1];

endmodule

// File: sv/rmq_div.sv
module rmq_div #(
    parameter int FRAC_BITS = 14,
    parameter int MW        = 18,
    parameter int RW        = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rmq_pkg::rmq_tag_t                    tag_in,
    input  logic [rmq_pkg::NUM_COMP-1:0][MW-1:0] mag_in,
    input  logic [RW-1:0]                        root,
    output logic                                 done,
    output logic [rmq_pkg::NUM_COMP-1:0][15:0]   quat,
    output logic                                 invalid
);
    import rmq_pkg::*;

    localparam int QB = FRAC_BITS + 2;
    localparam int NW = MW + FRAC_BITS + 1;
    localparam int EW = (QB + 1 > 16) ? QB + 1 : 16;
    localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

    // numerator build and overflow check
    logic [NUM_COMP-1:0][NW-1:0] num;
    logic [NUM_COMP-1:0][NW-1:0] hi;
    logic [RW:0]                 den;

    rmq_tag_t                    tag0_reg;
    logic [RW:0]                 den0_reg;
    logic [NUM_COMP-1:0][RW:0]   p0_reg;
    logic [NUM_COMP-1:0][QB-1:0] lo0_reg;
    logic [NUM_COMP-1:0]         sat0_reg;

    assign den = {root, 1'b0};

    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            num[i] = NW'({mag_in[i], {FRAC_BITS{1'b0}}}) + NW'(root);
            hi[i]  = num[i] >> QB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag0_reg <= '0;
        else
            tag0_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        den0_reg <= den;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            p0_reg[i]   <= hi[i][RW:0];
            lo0_reg[i]  <= num[i][QB-1:0];
            sat0_reg[i] <= (hi[i] >= NW'(den));
        end
    end

    // restoring division, one quotient bit per stage
    rmq_tag_t                    tag_reg [QB];
    logic [RW:0]                 den_reg [QB];
    logic [NUM_COMP-1:0][RW:0]   p_reg   [QB];
    logic [NUM_COMP-1:0][QB-1:0] lo_reg  [QB];
    logic [NUM_COMP-1:0][QB-1:0] q_reg   [QB];
    logic [NUM_COMP-1:0]         sat_reg [QB];

    for (genvar j = 0; j < QB; j++)
    begin : g_step
        rmq_tag_t                    tag_p;
        logic [RW:0]                 den_p;
        logic [NUM_COMP-1:0][RW:0]   p_p, p_next;
        logic [NUM_COMP-1:0][QB-1:0] lo_p, q_p, q_next;
        logic [NUM_COMP-1:0]         sat_p;

        if (j == 0)
        begin : g_first
            assign tag_p = tag0_reg;
            assign den_p = den0_reg;
            assign p_p   = p0_reg;
            assign lo_p  = lo0_reg;
            assign q_p   = '0;
            assign sat_p = sat0_reg;
        end
        else
        begin : g_next
            assign tag_p = tag_reg[j-1];
            assign den_p = den_reg[j-1];
            assign p_p   = p_reg[j-1];
            assign lo_p  = lo_reg[j-1];
            assign q_p   = q_reg[j-1];
            assign sat_p = sat_reg[j-1];
        end

        always_comb
        begin
            logic [RW+1:0] ps;
            for (int i = 0; i < NUM_COMP; i++)
            begin
                ps = {p_p[i], lo_p[i][QB-1-j]};
                if (ps >= {1'b0, den_p})
                begin
                    p_next[i] = (RW+1)'(ps - {1'b0, den_p});
                    q_next[i] = {q_p[i][QB-2:0], 1'b1};
                end
                else
                begin
                    p_next[i] = ps[RW:0];
                    q_next[i] = {q_p[i][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[j] <= '0;
            else
                tag_reg[j] <= tag_p;
        end

        always_ff @(posedge clk)
        begin
            den_reg[j] <= den_p;
            p_reg[j]   <= p_next;
            lo_reg[j]  <= lo_p;
            q_reg[j]   <= q_next;
            sat_reg[j] <= sat_p;
        end
    end

    // saturate, apply sign, output register
    rmq_tag_t                    tag_last;
    logic [NUM_COMP-1:0][15:0]   quat_next, quat_reg;
    logic                        done_reg, invalid_reg;

    assign tag_last = tag_reg[QB-1];

    always_comb
    begin
        logic [QB-1:0] qs;
        logic [EW-1:0] qe;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            qs = (sat_reg[QB-1][i] || q_reg[QB-1][i] > ONE_Q) ? ONE_Q : q_reg[QB-1][i];
            qe = EW'(qs);
            if (tag_last.neg[i])
                qe = -qe;
            quat_next[i] = tag_last.invalid ? 16'd0 : qe[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= tag_last.valid;
            invalid_reg <= tag_last.invalid;
        end
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= quat_next;
    end

    assign done    = done_reg;
    assign quat    = quat_reg;
    assign invalid = invalid_reg;

endmodule

// File: sv/rotation_matrix_to_quaternion.sv
// start edge to done strobe runs through the front end, square root and divider, where
// RW = ceil((max(FRAC_BITS,17) + 1 + FRAC_BITS) / 2) is the square root length
// (16 at 14)
// throughput: one transaction per cycle; busy stays low, every stage is a plain register
// the depth comes from the bit-per-stage square root and the bit-per-stage divider lanes
// reset: rst_n clears the valid bits and the done strobe; data registers are not reset
// here the receiver cannot stall: each result shows on the outputs for one cycle only
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] m00,
    input  logic signed [15:0] m01,
    input  logic signed [15:0] m02,
    input  logic signed [15:0] m10,
    input  logic signed [15:0] m11,
    input  logic signed [15:0] m12,
    input  logic signed [15:0] m20,
    input  logic signed [15:0] m21,
    input  logic signed [15:0] m22,
    output logic               done,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic               invalid
);
    import rmq_pkg::*;

    // pivot and component width, wide enough for one plus three elements
    localparam int TW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    // magnitude width once the sign is split off
    localparam int MW = TW - 1;
    // radicand is t shifted up by the fraction bits, rounded up to an even width
    localparam int VW = MW + FRAC_BITS;
    localparam int RW = (VW + (VW % 2)) / 2;

    rmq_tag_t                    fr_tag, sq_tag;
    logic [NUM_COMP-1:0][MW-1:0] fr_mag, sq_mag;
    logic [MW-1:0]               fr_t;
    logic [RW-1:0]               sq_root;
    logic [NUM_COMP-1:0][15:0]   quat;

    // every stage moves on each cycle, so a new transaction is always welcome
    assign busy = 1'b0;

    // branch choice, pivot t, raw components, then sign and magnitude split
    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .TW        (TW),
        .MW        (MW)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !busy),
        .m00   (m00),
        .m01   (m01),
        .m02   (m02),
        .m10   (m10),
        .m11   (m11),
        .m12   (m12),
        .m20   (m20),
        .m21   (m21),
        .m22   (m22),
        .tag   (fr_tag),
        .mag   (fr_mag),
        .t_mag (fr_t)
    );

    // truncated square root of t with fraction bits, one root bit per stage
    rmq_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .MW        (MW),
        .RW        (RW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (fr_tag),
        .mag_in  (fr_mag),
        .t_in    (fr_t),
        .tag_out (sq_tag),
        .mag_out (sq_mag),
        .root    (sq_root)
    );

    // four divider lanes, rounded quotient over twice the root, then saturation
    rmq_div #(
        .FRAC_BITS (FRAC_BITS),
        .MW        (MW),
        .RW        (RW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (sq_tag),
        .mag_in  (sq_mag),
        .root    (sq_root),
        .done    (done),
        .quat    (quat),
        .invalid (invalid)
    );

    assign quat_x = quat[LANE_X];
    assign quat_y = quat[LANE_Y];
    assign quat_z = quat[LANE_Z];
    assign quat_w = quat[LANE_W];

endmodule

// File: sim/testbench.sv
module testbench;

    import rmq_pkg::*;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    // pipeline depth: front end, square root and divider stages
    localparam int PIPE_LAT  = 4 + 16 + FRAC_BITS + 2;
    localparam int MAX_CYC   = 200000;
    localparam int N_RANDOM  = 2000;

    // one quaternion transaction as it leaves the block
    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic               inv;
    } quat_t;

    // one directed row: nine elements, optional typed-in answer
    typedef struct {
        logic signed [15:0] m [9];
        bit                 has_fixed;
        quat_t              fixed;
    } mat_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic               done;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic               invalid;

    quat_t    quat_queue[$];
    mat_row_t dir_rows[$];
    int       n_errors;
    int       n_sent;
    int       n_got;
    int       n_invalid;
    int       n_branch[4];
    longint   cyc;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .m00     (m00),
        .m01     (m01),
        .m02     (m02),
        .m10     (m10),
        .m11     (m11),
        .m12     (m12),
        .m20     (m20),
        .m21     (m21),
        .m22     (m22),
        .done    (done),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .quat_w  (quat_w),
        .invalid (invalid)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // bit-serial integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned rem, res, bt;
        rem = v;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > rem)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (rem >= res + bt)
            begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    // component times 0.5/sqrt(t), rounded half away from zero, saturated to one
    function automatic logic [15:0] scale_lane(input longint c, input longint unsigned r);
        longint unsigned mag, q;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        q   = ((mag << FRAC_BITS) + r) / (2 * r);
        if (q > ONE)
            q = ONE;
        if (c < 0)
            q = -q;
        return q[15:0];
    endfunction

    // expected quaternion for one matrix; also tallies the branch taken
    function automatic quat_t matrix_to_quat(input logic signed [15:0] m [9]);
        longint      a00, a01, a02, a10, a11, a12, a20, a21, a22, t;
        longint      c [4];
        longint unsigned r;
        rmq_branch_t br;
        quat_t       q;
        a00 = m[0]; a01 = m[1]; a02 = m[2];
        a10 = m[3]; a11 = m[4]; a12 = m[5];
        a20 = m[6]; a21 = m[7]; a22 = m[8];
        if (a22 < 0)
        begin
            if (a00 > a11)
            begin
                br = BR_X;
                t  = ONE + a00 - a11 - a22;
                c[LANE_X] = t;         c[LANE_Y] = a10 + a01;
                c[LANE_Z] = a02 + a20; c[LANE_W] = a21 - a12;
            end
            else
            begin
                br = BR_Y;
                t  = ONE - a00 + a11 - a22;
                c[LANE_X] = a10 + a01; c[LANE_Y] = t;
                c[LANE_Z] = a21 + a12; c[LANE_W] = a02 - a20;
            end
        end
        else if (a00 < -a11)
        begin
            br = BR_Z;
            t  = ONE - a00 - a11 + a22;
            c[LANE_X] = a02 + a20; c[LANE_Y] = a21 + a12;
            c[LANE_Z] = t;         c[LANE_W] = a10 - a01;
        end
        else
        begin
            br = BR_W;
            t  = ONE + a00 + a11 + a22;
            c[LANE_X] = a21 - a12; c[LANE_Y] = a02 - a20;
            c[LANE_Z] = a10 - a01; c[LANE_W] = t;
        end
        n_branch[br]++;
        if (t <= 0)
        begin
            n_invalid++;
            q = '{qx: 16'sd0, qy: 16'sd0, qz: 16'sd0, qw: 16'sd0, inv: 1'b1};
            return q;
        end
        r    = int_sqrt(longint'(t) << FRAC_BITS);
        q.qx = scale_lane(c[LANE_X], r);
        q.qy = scale_lane(c[LANE_Y], r);
        q.qz = scale_lane(c[LANE_Z], r);
        q.qw = scale_lane(c[LANE_W], r);
        q.inv = 1'b0;
        return q;
    endfunction

    // rotation-like matrix: permuted identity with random signs and jitter
    function automatic void rand_rotation(output logic signed [15:0] m [9]);
        int perm [3];
        int s;
        int tmp;
        int j;
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--)
        begin
            j        = $urandom_range(i, 0);
            tmp      = perm[i];
            perm[i]  = perm[j];
            perm[j]  = tmp;
        end
        for (int i = 0; i < 9; i++)
            m[i] = 16'($urandom_range(2000, 0) - 1000);
        for (int i = 0; i < 3; i++)
        begin
            s = $urandom_range(1, 0) ? ONE : -ONE;
            m[i*3 + perm[i]] = 16'(s - ((s > 0) ? $urandom_range(1500, 0)
                                                : -$urandom_range(1500, 0)));
        end
    endfunction

    // checker: results are sampled on the rising edge, done is a one-cycle strobe
    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && done)
        begin
            n_got++;
            if (quat_queue.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected transaction x=%0d y=%0d z=%0d w=%0d inv=%0b",
                         $time, quat_x, quat_y, quat_z, quat_w, invalid);
            end
            else
            begin
                want = quat_queue.pop_front();
                if (quat_x !== want.qx)
                begin
                    n_errors++;
                    $display("%0t: quat_x expected %0d actual %0d", $time, want.qx, quat_x);
                end
                if (quat_y !== want.qy)
                begin
                    n_errors++;
                    $display("%0t: quat_y expected %0d actual %0d", $time, want.qy, quat_y);
                end
                if (quat_z !== want.qz)
                begin
                    n_errors++;
                    $display("%0t: quat_z expected %0d actual %0d", $time, want.qz, quat_z);
                end
                if (quat_w !== want.qw)
                begin
                    n_errors++;
                    $display("%0t: quat_w expected %0d actual %0d", $time, want.qw, quat_w);
                end
                if (invalid !== want.inv)
                begin
                    n_errors++;
                    $display("%0t: invalid expected %0b actual %0b", $time, want.inv, invalid);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc > MAX_CYC)
            begin
                $display("timeout after %0d cycles", cyc);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // hold a matrix on the ports at the falling edge, wait for the accepting edge
    task automatic send_matrix(input logic signed [15:0] m [9], input quat_t want);
        @(negedge clk);
        start <= 1'b1;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
            {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
        do
            @(posedge clk);
        while (busy);
        quat_queue.push_back(want);
        n_sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // directed row helpers
    function automatic void add_row(input logic signed [15:0] m [9]);
        mat_row_t row;
        row.m         = m;
        row.has_fixed = 1'b0;
        row.fixed     = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_fixed(input logic signed [15:0] m [9], input quat_t q);
        mat_row_t row;
        row.m         = m;
        row.has_fixed = 1'b1;
        row.fixed     = q;
        dir_rows.push_back(row);
    endfunction

    initial
    begin
        logic signed [15:0] mm [9];
        quat_t want;
        int burst;

        n_errors  = 0;
        n_sent    = 0;
        n_got     = 0;
        n_invalid = 0;
        n_branch  = '{0, 0, 0, 0};
        start     = 1'b0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
        rst_n     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity: w branch, exact unit scalar
        add_fixed('{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384},
                  '{qx: 0, qy: 0, qz: 0, qw: 16'sd16384, inv: 1'b0});
        // half turn about x: x branch
        add_fixed('{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384},
                  '{qx: 16'sd16384, qy: 0, qz: 0, qw: 0, inv: 1'b0});
        // half turn about y: y branch
        add_fixed('{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384},
                  '{qx: 0, qy: 16'sd16384, qz: 0, qw: 0, inv: 1'b0});
        // half turn about z: z branch
        add_fixed('{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384},
                  '{qx: 0, qy: 0, qz: 16'sd16384, qw: 0, inv: 1'b0});
        // singular diagonal: y branch, pivot still positive
        add_row('{-16'sd8192, 0, 0, 0, 0, 0, 0, 0, -16'sd8192});
        // all zero: w branch with t = one
        add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        // out-of-range extremes
        add_row('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff});
        add_row('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000});
        add_row('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        // negated identity: y branch
        add_row('{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384});
        // large off-diagonal elements on the y branch
        add_row('{-16'sd8191, 16'sd16384, 16'sd16384, 16'sd16384, 0,
                  16'sd16384, -16'sd16384, 16'sd16384, -16'sd8192});
        // ties on the branch compares
        add_row('{16'sd100, 16'sd5, 16'sd6, 16'sd7, 16'sd100, 16'sd8, 16'sd9, 16'sd10, -16'sd1});
        add_row('{16'sd100, 16'sd5, 16'sd6, 16'sd7, -16'sd100, 16'sd8, 16'sd9, 16'sd10, 16'sd0});
        // quarter turn and eighth turn about z
        add_row('{0, -16'sd16384, 0, 16'sd16384, 0, 0, 0, 0, 16'sd16384});
        add_row('{16'sd11585, -16'sd11585, 0, 16'sd11585, 16'sd11585, 0, 0, 0, 16'sd16384});

        foreach (dir_rows[i])
        begin
            want = dir_rows[i].has_fixed ? dir_rows[i].fixed : matrix_to_quat(dir_rows[i].m);
            if (dir_rows[i].has_fixed)
                void'(matrix_to_quat(dir_rows[i].m));
            send_matrix(dir_rows[i].m, want);
            if ($urandom_range(3, 0) == 0)
                idle_gap($urandom_range(3, 1));
        end

        // random part: mostly rotation-like matrices, some bounded random and some raw bit patterns
        burst = 0;
        for (int k = 0; k < N_RANDOM; k++)
        begin
            if ($urandom_range(9, 0) < 7)
                rand_rotation(mm);
            else if ($urandom_range(1, 0))
                for (int i = 0; i < 9; i++)
                    mm[i] = 16'($urandom_range(32768, 0) - 16384);
            else
                for (int i = 0; i < 9; i++)
                    mm[i] = 16'($urandom());
            send_matrix(mm, matrix_to_quat(mm));
            // bursts of random length, then a random gap; long bursts run flat out
            if (burst == 0)
            begin
                idle_gap($urandom_range(4, 0) == 0 ? $urandom_range(60, 1)
                                                   : $urandom_range(5, 0));
                burst = $urandom_range(40, 1);
            end
            else
                burst--;
        end
        @(negedge clk);
        start <= 1'b0;

        // drain the pipeline, then wait on for stray strobes
        while (quat_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("%0d matrices sent, %0d quaternions checked, %0d invalid", n_sent, n_got,
                 n_invalid);
        $display("branches x/y/z/w: %0d/%0d/%0d/%0d", n_branch[BR_X], n_branch[BR_Y],
                 n_branch[BR_Z], n_branch[BR_W]);
        if (n_errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
sim/testbench.sv
